[rtl/button_binary_watch_controller_macros.svh]
// Assertion macros for the binary watch controller.
// Used by the modules that carry concurrent checks; expects clk and rst_n in scope.
`ifndef BUTTON_BINARY_WATCH_CONTROLLER_MACROS_SVH
`define BUTTON_BINARY_WATCH_CONTROLLER_MACROS_SVH

`ifndef SYNTHESIS
// Check a condition at every clock edge outside reset.
`define BBW_ASSERT_ALWAYS(label, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("watch check failed");
// Check that an antecedent implies a consequent in the same cycle.
`define BBW_ASSERT_IMPLY(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("watch check failed");
`else
`define BBW_ASSERT_ALWAYS(label, cond)
`define BBW_ASSERT_IMPLY(label, ante, cons)
`endif

`endif

[rtl/bbw_pkg.sv]
// Shared types and constants for the binary watch controller.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package bbw_pkg;

  // Configuration port geometry
  localparam int CFG_AW = 5;
  localparam int CFG_DW = 32;

  // Timekeeping limits
  localparam logic [5:0] SEC_PER_MIN  = 6'd60;
  localparam logic [6:0] SEC_TWO_MIN  = 7'd120;
  localparam logic [3:0] HOUR_LIMIT   = 4'd13;
  localparam logic [3:0] HOUR_FIRST   = 4'd1;
  localparam logic [1:0] SET_ACCEL_START = 2'd2;

  // Reset values
  localparam logic [5:0] RST_MINUTES = 6'd6;
  localparam logic [3:0] RST_HOURS   = 4'd3;
  localparam logic [5:0] RST_PRESCALE = 6'd32;
  localparam logic [5:0] RST_DISPLAY  = 6'd10;
  localparam logic [5:0] RST_HOLD     = 6'd3;
  localparam logic [5:0] RST_PACE     = 6'd50;
  localparam logic [4:0] RST_STEP     = 5'd5;
  localparam logic [5:0] RST_FLOOR    = 6'd5;
  localparam logic [1:0] RST_REPEAT   = 2'd3;

  // Register word indexes (byte address / 4)
  typedef enum logic [2:0] {
    REG_PRESCALE = 3'd0,
    REG_DISPLAY  = 3'd1,
    REG_HOLD     = 3'd2,
    REG_START    = 3'd3,
    REG_STEP     = 3'd4,
    REG_FLOOR    = 3'd5,
    REG_REPEAT   = 3'd6
  } reg_idx_t;

  // Input kinds
  localparam logic KIND_TIME = 1'b0;
  localparam logic KIND_PACE = 1'b1;

  typedef enum logic [1:0] {
    MODE_OFF     = 2'd0,
    MODE_ARM     = 2'd1,
    MODE_DISPLAY = 2'd2,
    MODE_SETTING = 2'd3
  } mode_t;

  typedef struct packed {
    logic [5:0] prescale_ticks;
    logic [5:0] display_seconds;
    logic [5:0] hold_seconds;
    logic [5:0] start_pace;
    logic [4:0] pace_step;
    logic [5:0] pace_floor;
    logic [1:0] pace_repeat;
  } cfg_t;

  typedef struct packed {
    logic kind;
    logic button_pressed;
  } in_t;

  typedef struct packed {
    logic [3:0] hour_leds;
    logic [5:0] minute_leds;
    logic       second_led;
    logic       display_on;
    logic       setting_active;
  } out_t;

endpackage

[rtl/button_binary_watch_controller.sv]
// Binary watch controller, usage notes:
//   Input channel (in_valid / in_stall / in_item) carries one request per tick:
//   kind 0 is a timekeeping tick, kind 1 a pace tick, with the button level.
//   Result channel (out_valid / out_stall / out_item) returns exactly one
//   result per request, in order: the LED pattern after that tick.
//   Path: an accepted request waits in the input stage register, and its
//   result is written into the result register once that register can advance.
//   Throughput: one request per cycle unless out_stall holds a result, set by
//   the single state-update stage between the input and result registers.
//   Stall: while out_stall holds a waiting result, the staged request stays
//   put and in_stall rises; nothing is dropped or repeated.
//   Reset (rst_n low, synchronous): time 3:06:00, display off, registers at
//   their defaults, both channels empty.
//   Configuration: APB-style port, 32-bit words at byte address 4*index;
//   write only while no request is in flight.
// Depends on bbw_pkg, bbw_cfg and bbw_core.
`timescale 1ns / 1ps

module button_binary_watch_controller
  import bbw_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  in_t               in_item,
  output logic              out_valid,
  input  logic              out_stall,
  output out_t              out_item,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready
);

  cfg_t cfg;

  // Register file
  bbw_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Watch datapath
  bbw_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule

[rtl/bbw_cfg.sv]
// Configuration register file with an APB-style access port.
// Depends on bbw_pkg for the register layout and reset values.
`timescale 1ns / 1ps

module bbw_cfg
  import bbw_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  cfg_t     cfg_r;
  logic     wr_en;
  reg_idx_t idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = reg_idx_t'(paddr[CFG_AW-1:2]);
  assign cfg    = cfg_r;

  // Write registers, masked to their widths
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.prescale_ticks  <= RST_PRESCALE;
      cfg_r.display_seconds <= RST_DISPLAY;
      cfg_r.hold_seconds    <= RST_HOLD;
      cfg_r.start_pace      <= RST_PACE;
      cfg_r.pace_step       <= RST_STEP;
      cfg_r.pace_floor      <= RST_FLOOR;
      cfg_r.pace_repeat     <= RST_REPEAT;
    end else if (wr_en) begin
      unique case (idx)
        REG_PRESCALE: cfg_r.prescale_ticks  <= pwdata[5:0];
        REG_DISPLAY:  cfg_r.display_seconds <= pwdata[5:0];
        REG_HOLD:     cfg_r.hold_seconds    <= pwdata[5:0];
        REG_START:    cfg_r.start_pace      <= pwdata[5:0];
        REG_STEP:     cfg_r.pace_step       <= pwdata[4:0];
        REG_FLOOR:    cfg_r.pace_floor      <= pwdata[5:0];
        REG_REPEAT:   cfg_r.pace_repeat     <= pwdata[1:0];
        default: ;
      endcase
    end
  end

  // Read back the addressed register
  always_comb begin
    prdata = '0;
    unique case (idx)
      REG_PRESCALE: prdata[5:0] = cfg_r.prescale_ticks;
      REG_DISPLAY:  prdata[5:0] = cfg_r.display_seconds;
      REG_HOLD:     prdata[5:0] = cfg_r.hold_seconds;
      REG_START:    prdata[5:0] = cfg_r.start_pace;
      REG_STEP:     prdata[4:0] = cfg_r.pace_step;
      REG_FLOOR:    prdata[5:0] = cfg_r.pace_floor;
      REG_REPEAT:   prdata[1:0] = cfg_r.pace_repeat;
      default:      prdata = '0;
    endcase
  end

endmodule

[rtl/bbw_core.sv]
// Watch core: input stage, timekeeping and mode state, result register.
// Depends on bbw_pkg and the assertion macros header.
`timescale 1ns / 1ps

`include "button_binary_watch_controller_macros.svh"

module bbw_core
  import bbw_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  cfg_t cfg,
  input  logic in_valid,
  output logic in_stall,
  input  in_t  in_item,
  output logic out_valid,
  input  logic out_stall,
  output out_t out_item
);

  // Input stage
  logic stg_valid_r;
  in_t  stg_r;
  // Result register
  logic out_valid_r;
  out_t out_r;
  out_t out_nxt;
  // Watch state
  mode_t      mode_r, mode_nxt;
  logic       latch_r, latch_nxt;
  logic [5:0] tick_r, tick_nxt;
  logic [5:0] sec_r, sec_nxt;
  logic [5:0] min_r, min_nxt;
  logic [3:0] hour_r, hour_nxt;
  logic [5:0] off_sec_r, off_sec_nxt;
  logic [5:0] enter_sec_r, enter_sec_nxt;
  logic [5:0] pace_r, pace_nxt;
  logic [1:0] accel_r, accel_nxt;
  logic [5:0] wait_r, wait_nxt;

  logic adv;
  logic fire;

  assign adv       = !out_valid_r || !out_stall;
  assign fire      = stg_valid_r && adv;
  assign in_stall  = stg_valid_r && !adv;
  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  // Advance the minute with carry into hours (12 wraps to 1)
  function automatic logic [9:0] next_minute(input logic [3:0] h, input logic [5:0] m);
    logic [5:0] m1;
    logic [3:0] h1;
    m1 = m + 6'd1;
    h1 = h;
    if (m1 >= SEC_PER_MIN) begin
      m1 = '0;
      h1 = h + 4'd1;
      if (h1 >= HOUR_LIMIT) h1 = HOUR_FIRST;
    end
    return {h1, m1};
  endfunction

  // Second count plus an offset, modulo 60
  function automatic logic [5:0] add_mod60(input logic [5:0] s, input logic [5:0] d);
    logic [6:0] sum;
    sum = {1'b0, s} + {1'b0, d};
    if (sum >= SEC_TWO_MIN)          sum = sum - SEC_TWO_MIN;
    else if (sum >= {1'b0, SEC_PER_MIN}) sum = sum - {1'b0, SEC_PER_MIN};
    return sum[5:0];
  endfunction

  // Next state for the staged request
  always_comb begin
    logic [5:0] t1;
    logic [5:0] s1;
    logic [1:0] a1;
    logic       pressed;
    mode_nxt      = mode_r;
    latch_nxt     = latch_r;
    tick_nxt      = tick_r;
    sec_nxt       = sec_r;
    min_nxt       = min_r;
    hour_nxt      = hour_r;
    off_sec_nxt   = off_sec_r;
    enter_sec_nxt = enter_sec_r;
    pace_nxt      = pace_r;
    accel_nxt     = accel_r;
    wait_nxt      = wait_r;
    pressed       = stg_r.button_pressed;
    t1            = tick_r + 6'd1;
    s1            = sec_r + 6'd1;
    a1            = (accel_r != 2'd0) ? accel_r - 2'd1 : 2'd0;

    if (stg_r.kind == KIND_TIME) begin
      // Timekeeping tick: hold time while setting
      if (mode_r != MODE_SETTING) begin
        tick_nxt = t1;
        if (t1 >= cfg.prescale_ticks) begin
          tick_nxt = '0;
          sec_nxt  = s1;
          if (s1 >= SEC_PER_MIN) begin
            sec_nxt = '0;
            {hour_nxt, min_nxt} = next_minute(hour_r, min_r);
          end
        end
      end
    end else if (wait_r != 6'd0) begin
      // Pace tick while waiting out the pace
      wait_nxt = wait_r - 6'd1;
    end else begin
      unique case (mode_r)
        MODE_OFF: begin
          if (pressed) begin
            mode_nxt  = MODE_ARM;
            latch_nxt = 1'b1;
          end else begin
            latch_nxt = 1'b0;
          end
        end
        MODE_ARM: begin
          off_sec_nxt   = add_mod60(sec_r, cfg.display_seconds);
          enter_sec_nxt = add_mod60(sec_r, cfg.hold_seconds);
          mode_nxt      = MODE_DISPLAY;
        end
        MODE_DISPLAY: begin
          priority if (off_sec_r == sec_r) begin
            mode_nxt = MODE_OFF;
          end else if (pressed && !latch_r) begin
            mode_nxt  = MODE_ARM;
            latch_nxt = 1'b1;
          end else if (enter_sec_r == sec_r && pressed && latch_r) begin
            mode_nxt  = MODE_SETTING;
            pace_nxt  = cfg.start_pace;
            accel_nxt = SET_ACCEL_START;
            wait_nxt  = '0;
          end else if (!pressed && latch_r) begin
            latch_nxt = 1'b0;
          end else begin
            latch_nxt = latch_r;
          end
        end
        MODE_SETTING: begin
          if (pressed) begin
            sec_nxt   = '0;
            {hour_nxt, min_nxt} = next_minute(hour_r, min_r);
            accel_nxt = a1;
            if (a1 == 2'd0 && pace_r > cfg.pace_floor) begin
              accel_nxt = cfg.pace_repeat;
              pace_nxt  = (pace_r > {1'b0, cfg.pace_step}) ?
                          pace_r - {1'b0, cfg.pace_step} : 6'd0;
            end
          end else begin
            mode_nxt = MODE_ARM;
          end
          wait_nxt = pace_nxt;
        end
        default: mode_nxt = MODE_OFF;
      endcase
    end
  end

  // Result fields from the updated state
  always_comb begin
    out_nxt = '0;
    if (mode_nxt != MODE_OFF) begin
      out_nxt.hour_leds      = hour_nxt;
      out_nxt.minute_leds    = min_nxt;
      out_nxt.second_led     = (mode_nxt == MODE_SETTING) ? 1'b0 : sec_nxt[0];
      out_nxt.display_on     = 1'b1;
      out_nxt.setting_active = (mode_nxt == MODE_SETTING);
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
      mode_r      <= MODE_OFF;
      latch_r     <= 1'b0;
      tick_r      <= '0;
      sec_r       <= '0;
      min_r       <= RST_MINUTES;
      hour_r      <= RST_HOURS;
      off_sec_r   <= '0;
      enter_sec_r <= '0;
      pace_r      <= '0;
      accel_r     <= '0;
      wait_r      <= '0;
    end else begin
      if (!in_stall) stg_valid_r <= in_valid;
      if (fire) begin
        out_valid_r <= 1'b1;
        mode_r      <= mode_nxt;
        latch_r     <= latch_nxt;
        tick_r      <= tick_nxt;
        sec_r       <= sec_nxt;
        min_r       <= min_nxt;
        hour_r      <= hour_nxt;
        off_sec_r   <= off_sec_nxt;
        enter_sec_r <= enter_sec_nxt;
        pace_r      <= pace_nxt;
        accel_r     <= accel_nxt;
        wait_r      <= wait_nxt;
      end else if (adv) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (!in_stall) stg_r <= in_item;
    if (fire)      out_r <= out_nxt;
  end

  `BBW_ASSERT_ALWAYS(a_clock_range, sec_r < SEC_PER_MIN && min_r < SEC_PER_MIN)
  `BBW_ASSERT_ALWAYS(a_hour_range, hour_r != 4'd0 && hour_r < HOUR_LIMIT)
  `BBW_ASSERT_IMPLY(a_stall_full, in_stall, stg_valid_r && out_valid_r)
  `BBW_ASSERT_IMPLY(a_setting_out, out_valid_r && out_r.setting_active, out_r.display_on)
  `BBW_ASSERT_IMPLY(a_setting_dot, out_valid_r && out_r.setting_active, !out_r.second_led)
  `BBW_ASSERT_IMPLY(a_dark_out, out_valid_r && !out_r.display_on, out_r == '0)

endmodule

[dv/tb_top.sv]
`timescale 1ns / 1ps
// Self-checking bench for button_binary_watch_controller: drives tick requests over
// valid/stall, programs the APB registers and checks each LED result against a watch
// predictor kept in the bench. Depends on bbw_pkg and the controller RTL.

module tb_top;
  import bbw_pkg::*;

  // Decoded word address with no register behind it
  localparam int unsigned REG_SPARE = 7;
  localparam int DRAIN_CYCLES = 8;
  localparam int RUN_LIMIT_NS = 600_000;
  localparam out_t LEDS_DARK = '0;
  localparam out_t LEDS_START = '{4'd3, 6'd6, 1'b0, 1'b1, 1'b0};

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid;
  logic              in_stall;
  in_t               in_item;
  logic              out_valid;
  logic              out_stall;
  out_t              out_item;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [CFG_AW-1:0] paddr;
  logic [CFG_DW-1:0] pwdata;
  logic [CFG_DW-1:0] prdata;
  logic              pready;

  button_binary_watch_controller i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always #1 clk = ~clk;

  // Watch predictor: registers and state
  cfg_t       wcfg;
  mode_t      w_mode;
  logic       w_latched;
  logic [5:0] w_ticks, w_sec, w_min, w_off_sec, w_enter_sec, w_pace, w_pace_wait;
  logic [3:0] w_hour;
  logic [1:0] w_accel;

  out_t led_expect_q[$];
  int   err_count = 0;
  bit   tx_calm = 1'b0;
  bit   rx_calm = 1'b0;

  typedef struct {
    bit          is_write;
    int unsigned reg_no;
    logic [31:0] wdata;
    in_t         req;
    bit          typed;
    out_t        want;
  } plan_row_t;

  plan_row_t plan_q[$];

  function automatic void watch_reset();
    wcfg = '{RST_PRESCALE, RST_DISPLAY, RST_HOLD, RST_PACE, RST_STEP, RST_FLOOR, RST_REPEAT};
    w_mode = MODE_OFF;
    w_latched = 1'b0;
    w_ticks = '0;
    w_sec = '0;
    w_min = RST_MINUTES;
    w_hour = RST_HOURS;
    w_off_sec = '0;
    w_enter_sec = '0;
    w_pace = '0;
    w_accel = '0;
    w_pace_wait = '0;
  endfunction

  // Advance the minute, carry into the 12-hour count
  function automatic void bump_minute();
    w_min = w_min + 6'd1;
    if (w_min >= SEC_PER_MIN) begin
      w_min = '0;
      w_hour = w_hour + 4'd1;
      if (w_hour >= HOUR_LIMIT) w_hour = HOUR_FIRST;
    end
  endfunction

  // Prescaler and seconds; frozen while setting
  function automatic void count_time_tick();
    if (w_mode != MODE_SETTING) begin
      w_ticks = w_ticks + 6'd1;
      if (w_ticks >= wcfg.prescale_ticks) begin
        w_ticks = '0;
        w_sec = w_sec + 6'd1;
        if (w_sec >= SEC_PER_MIN) begin
          w_sec = '0;
          bump_minute();
        end
      end
    end
  endfunction

  // One setting step: advance the minute and shorten the pace, or leave on release
  function automatic void step_setting(logic press);
    if (press) begin
      w_sec = '0;
      bump_minute();
      if (w_accel != 2'd0) w_accel = w_accel - 2'd1;
      if (w_accel == 2'd0 && w_pace > wcfg.pace_floor) begin
        w_accel = wcfg.pace_repeat;
        w_pace = (w_pace > {1'b0, wcfg.pace_step}) ? w_pace - {1'b0, wcfg.pace_step} : 6'd0;
      end
    end else begin
      w_mode = MODE_ARM;
    end
    w_pace_wait = w_pace;
  endfunction

  function automatic void step_pace_tick(logic press);
    if (w_pace_wait != 6'd0) begin
      w_pace_wait = w_pace_wait - 6'd1;
    end else begin
      case (w_mode)
        MODE_OFF: begin
          if (press) w_mode = MODE_ARM;
          w_latched = press;
        end
        MODE_ARM: begin
          w_off_sec = 6'((int'(w_sec) + int'(wcfg.display_seconds)) % int'(SEC_PER_MIN));
          w_enter_sec = 6'((int'(w_sec) + int'(wcfg.hold_seconds)) % int'(SEC_PER_MIN));
          w_mode = MODE_DISPLAY;
        end
        MODE_DISPLAY: begin
          if (w_off_sec == w_sec) begin
            w_mode = MODE_OFF;
          end else if (press && !w_latched) begin
            w_mode = MODE_ARM;
            w_latched = 1'b1;
          end else if (w_enter_sec == w_sec && press && w_latched) begin
            w_mode = MODE_SETTING;
            w_pace = wcfg.start_pace;
            w_accel = SET_ACCEL_START;
            w_pace_wait = '0;
          end else if (!press && w_latched) begin
            w_latched = 1'b0;
          end
        end
        default: step_setting(press);
      endcase
    end
  endfunction

  // Apply one request to the predictor and return the LED pattern after it
  function automatic out_t watch_leds(in_t req);
    out_t leds;
    if (req.kind == KIND_PACE) step_pace_tick(req.button_pressed);
    else count_time_tick();
    leds = '0;
    if (w_mode != MODE_OFF) begin
      leds.hour_leds = w_hour;
      leds.minute_leds = w_min;
      leds.second_led = (w_mode == MODE_SETTING) ? 1'b0 : w_sec[0];
      leds.display_on = 1'b1;
      leds.setting_active = (w_mode == MODE_SETTING);
    end
    return leds;
  endfunction

  // Mirror a register write; unknown indexes drop, values mask to width
  function automatic void apply_reg(int unsigned idx, logic [31:0] val);
    case (idx)
      REG_PRESCALE: wcfg.prescale_ticks = val[5:0];
      REG_DISPLAY:  wcfg.display_seconds = val[5:0];
      REG_HOLD:     wcfg.hold_seconds = val[5:0];
      REG_START:    wcfg.start_pace = val[5:0];
      REG_STEP:     wcfg.pace_step = val[4:0];
      REG_FLOOR:    wcfg.pace_floor = val[5:0];
      REG_REPEAT:   wcfg.pace_repeat = val[1:0];
      default: ;
    endcase
  endfunction

  function automatic void plan_write(int unsigned idx, logic [31:0] val);
    plan_row_t row;
    row.is_write = 1'b1;
    row.reg_no = idx;
    row.wdata = val;
    row.req = '0;
    row.typed = 1'b0;
    row.want = '0;
    plan_q.push_back(row);
  endfunction

  function automatic void plan_tick(logic kind, logic press, bit typed = 1'b0,
                                    out_t want = '0);
    plan_row_t row;
    row.is_write = 1'b0;
    row.reg_no = 0;
    row.wdata = '0;
    row.req = '{kind: kind, button_pressed: press};
    row.typed = typed;
    row.want = want;
    plan_q.push_back(row);
  endfunction

  // Drop valid and hold until every expected result is back
  task automatic hold_until_drained();
    in_valid <= 1'b0;
    while (led_expect_q.size() != 0) @(negedge clk);
  endtask

  task automatic reg_write(int unsigned idx, logic [31:0] val);
    hold_until_drained();
    repeat (DRAIN_CYCLES) @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= CFG_AW'(idx * 4);
    pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    apply_reg(idx, val);
  endtask

  // Send one request after a random gap; record its expected LEDs on acceptance
  task automatic send_tick(in_t req, bit typed, out_t want);
    int   gap;
    out_t leds;
    gap = tx_calm ? 0 : $urandom_range(0, 10);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_item <= req;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    leds = watch_leds(req);
    led_expect_q.push_back(typed ? want : leds);
    @(negedge clk);
  endtask

  // Program a setting, then run press and release episodes of random content
  task automatic run_phase(cfg_t c, int n);
    int  left, len, pace_pct;
    bit  btn;
    in_t req;
    reg_write(REG_PRESCALE, 32'(c.prescale_ticks));
    reg_write(REG_DISPLAY, 32'(c.display_seconds));
    reg_write(REG_HOLD, 32'(c.hold_seconds));
    reg_write(REG_START, 32'(c.start_pace));
    reg_write(REG_STEP, 32'(c.pace_step));
    reg_write(REG_FLOOR, 32'(c.pace_floor));
    reg_write(REG_REPEAT, 32'(c.pace_repeat));
    btn = 1'b0;
    left = n;
    while (left > 0) begin
      btn = ~btn;
      if (btn) len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : $urandom_range(20, 150);
      else len = $urandom_range(1, 40);
      pace_pct = $urandom_range(20, 80);
      tx_calm = ($urandom_range(0, 2) == 0);
      for (int k = 0; k < len && left > 0; k++) begin
        req.kind = ($urandom_range(0, 99) < pace_pct) ? KIND_PACE : KIND_TIME;
        // occasional bounce against the held level
        req.button_pressed = ($urandom_range(0, 19) == 0) ? ~btn : btn;
        send_tick(req, 1'b0, '0);
        left--;
        if (left == n / 2) hold_until_drained();
      end
    end
  endtask

  // Result side: raise out_stall at random before taking each result
  initial begin
    int n_stall;
    int n_seen;
    n_seen = 0;
    out_stall = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (n_seen % 32 == 0) rx_calm = ($urandom_range(0, 2) == 0);
      n_stall = rx_calm ? 0 : $urandom_range(0, 10);
      if (n_stall != 0) begin
        out_stall <= 1'b1;
        repeat (n_stall) @(negedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      n_seen++;
    end
  end

  // Compare each accepted result with the oldest expectation
  always @(posedge clk) begin
    out_t exp_leds;
    if (rst_n && out_valid && !out_stall) begin
      if (led_expect_q.size() == 0) begin
        $error("result with nothing expected: %h", out_item);
        err_count++;
      end else begin
        exp_leds = led_expect_q.pop_front();
        if (out_item.hour_leds !== exp_leds.hour_leds) begin
          $error("hour_leds: expected %0d, got %0d", exp_leds.hour_leds, out_item.hour_leds);
          err_count++;
        end
        if (out_item.minute_leds !== exp_leds.minute_leds) begin
          $error("minute_leds: expected %0d, got %0d", exp_leds.minute_leds,
                 out_item.minute_leds);
          err_count++;
        end
        if (out_item.second_led !== exp_leds.second_led) begin
          $error("second_led: expected %0d, got %0d", exp_leds.second_led, out_item.second_led);
          err_count++;
        end
        if (out_item.display_on !== exp_leds.display_on) begin
          $error("display_on: expected %0d, got %0d", exp_leds.display_on, out_item.display_on);
          err_count++;
        end
        if (out_item.setting_active !== exp_leds.setting_active) begin
          $error("setting_active: expected %0d, got %0d", exp_leds.setting_active,
                 out_item.setting_active);
          err_count++;
        end
      end
    end
  end

  // Hard stop for a hung handshake
  initial begin
    #(RUN_LIMIT_NS);
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    cfg_t c;
    in_valid = 1'b0;
    in_item = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    watch_reset();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: reset view, press, arm, display, setting steps, release, switch-off
    plan_tick(KIND_TIME, 1'b0, 1'b1, LEDS_DARK);
    plan_tick(KIND_PACE, 1'b0, 1'b1, LEDS_DARK);
    plan_tick(KIND_PACE, 1'b1, 1'b1, LEDS_START);
    plan_tick(KIND_PACE, 1'b1, 1'b1, LEDS_START);
    plan_write(REG_SPARE, 32'hFFFF_FFFF);
    // upper bits mask off: prescale of zero counts a second per tick
    plan_write(REG_PRESCALE, 32'hFFFF_FFC0);
    plan_write(REG_START, 32'd2);
    plan_write(REG_STEP, 32'd31);
    plan_write(REG_FLOOR, 32'd0);
    plan_write(REG_REPEAT, 32'd0);
    plan_write(REG_HOLD, 32'd1);
    plan_tick(KIND_TIME, 1'b1);
    plan_tick(KIND_TIME, 1'b0);
    plan_tick(KIND_TIME, 1'b1);
    plan_tick(KIND_PACE, 1'b1);
    plan_tick(KIND_PACE, 1'b1);
    plan_tick(KIND_PACE, 1'b1);
    plan_tick(KIND_PACE, 1'b1);
    plan_tick(KIND_PACE, 1'b1);
    plan_tick(KIND_TIME, 1'b1);
    plan_tick(KIND_PACE, 1'b1);
    plan_tick(KIND_PACE, 1'b0);
    plan_tick(KIND_PACE, 1'b0);
    plan_tick(KIND_PACE, 1'b0);
    plan_tick(KIND_PACE, 1'b1);
    plan_tick(KIND_PACE, 1'b1);
    plan_write(REG_DISPLAY, 32'd0);
    plan_tick(KIND_TIME, 1'b0);
    plan_tick(KIND_PACE, 1'b1);
    plan_tick(KIND_PACE, 1'b0);
    plan_tick(KIND_PACE, 1'b0);
    plan_tick(KIND_PACE, 1'b0);
    plan_tick(KIND_PACE, 1'b0);
    plan_tick(KIND_PACE, 1'b0);
    foreach (plan_q[i]) begin
      if (plan_q[i].is_write) reg_write(plan_q[i].reg_no, plan_q[i].wdata);
      else send_tick(plan_q[i].req, plan_q[i].typed, plan_q[i].want);
    end

    // Random: fixed corner settings, then drawn ones
    run_phase('{6'd2, 6'd10, 6'd3, 6'd8, 5'd2, 6'd1, 2'd1}, 170);
    run_phase('{6'd1, 6'd1, 6'd1, 6'd1, 5'd1, 6'd0, 2'd1}, 170);
    run_phase('{6'd63, 6'd59, 6'd59, 6'd63, 5'd31, 6'd63, 2'd3}, 150);
    run_phase('0, 170);
    for (int ph = 0; ph < 3; ph++) begin
      c.prescale_ticks = 6'($urandom_range(0, 4));
      c.display_seconds = 6'($urandom_range(0, 63));
      c.hold_seconds = 6'($urandom_range(0, 8));
      c.start_pace = 6'($urandom_range(0, 20));
      c.pace_step = 5'($urandom_range(0, 31));
      c.pace_floor = 6'($urandom_range(0, 15));
      c.pace_repeat = 2'($urandom_range(0, 3));
      run_phase(c, 170);
    end

    hold_until_drained();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
